[rtl/skset_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key set package
// Shared types and constants for the sorted key set and its storage cells.
// ----------------------------------------------------------------------------
package skset_pkg;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;

  // Fixed field widths of the request and response words.
  localparam int KEY_W   = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic               was_present;
    logic               changed;
    logic               full_error;
    logic               index_error;
    logic [KEY_W-1:0]   entry_value;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic capture;
    logic do_insert;
    logic do_remove;
  } cell_ctl_t;

endpackage

[rtl/skset_cell.sv]
// ----------------------------------------------------------------------------
// Sorted key set storage cell
// Holds one slot of the sorted row, compares it with the request key and
// takes its neighbor's key when the row shifts for an insert or a removal.
// ----------------------------------------------------------------------------
module skset_cell #(
  parameter int KEY_BITS = skset_pkg::KEY_BITS_DEF,
  parameter int CNT_W    = 7,
  parameter int INDEX    = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  skset_pkg::cell_ctl_t  ctl,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [skset_pkg::POS_W-1:0] position,
  input  logic [CNT_W-1:0]      count,
  input  logic [KEY_BITS-1:0]   ins_key,
  input  logic                  left_lt,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic [KEY_BITS-1:0]   right_key,
  output logic                  lt,
  output logic                  eq,
  output logic                  sel,
  output logic [KEY_BITS-1:0]   entry,
  output logic [KEY_BITS-1:0]   rd_word
);

  localparam bit POS_REACH = INDEX < (1 << skset_pkg::POS_W);

  logic occupied;

  // A slot holds a key when its index is below the count.
  assign occupied = CNT_W'(INDEX) < count;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt  <= 1'b0;
      eq  <= 1'b0;
      sel <= 1'b0;
    end else if (ctl.capture) begin
      lt  <= occupied && (entry < cmp_key);
      eq  <= occupied && (entry == cmp_key);
      sel <= occupied && POS_REACH &&
             (position == skset_pkg::POS_W'(INDEX));
    end
  end

  // The row below the insert slot keeps its keys, the slot takes the new
  // key and everything above it moves one place up. A removal pulls every
  // slot at or above the match down by one.
  always_ff @(posedge clk) begin
    if (ctl.do_insert) begin
      if (left_lt && !lt) begin
        entry <= ins_key;
      end else if (!left_lt) begin
        entry <= left_key;
      end
    end else if (ctl.do_remove) begin
      if (!lt) begin
        entry <= right_key;
      end
    end
  end

  assign rd_word = sel ? entry : '0;

endmodule

[rtl/sorted_key_set.sv]
// A request word is accepted in the idle state and its response word is
// loaded into the output register in the update state, once that register
// is free. No new request is accepted until the update of the last one
// commits; a stalled response holds the row in the update state.
// Reset: synchronous, active high; the set comes up empty. Stored keys are
// not cleared, only the count is.
// ----------------------------------------------------------------------------
// Sorted key set
// A set of distinct keys kept in ascending order in a row of storage cells.
// Each request adds, removes, tests or reads one key and yields one response.
// ----------------------------------------------------------------------------
module sorted_key_set #(
  parameter int CAPACITY = skset_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = skset_pkg::KEY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  skset_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output skset_pkg::rsp_t   rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // The sequencer has two states: waiting for a request word, and updating
  // the row once the cells have registered their compare flags.
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t                st;
  state_t                st_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  skset_pkg::op_t        op;
  logic [KEY_BITS-1:0]   key;

  skset_pkg::cell_ctl_t  ctl;
  logic [KEY_BITS-1:0]   cmp_key;

  logic                  lt      [CAPACITY];
  logic                  eq      [CAPACITY];
  logic                  sel     [CAPACITY];
  logic [KEY_BITS-1:0]   entry   [CAPACITY];
  logic [KEY_BITS-1:0]   rd_word [CAPACITY];

  logic                  hit;
  logic                  any_sel;
  logic [KEY_BITS-1:0]   rd_value;
  logic                  commit;
  logic                  full;
  skset_pkg::rsp_t       rsp_next;

  // Keys are truncated to the stored width before anything else sees them.
  assign cmp_key   = KEY_BITS'(req.key);
  assign req_ready = (st == S_IDLE);
  assign full      = (count == CNT_W'(CAPACITY));

  // The response is committed only when the output register is free, so
  // the row holds its flags while a response waits.
  assign commit = (st == S_UPDATE) && (!rsp_valid || rsp_ready);

  // ---------------------------------------------------------------------------
  // The row of cells. Each cell sees the registered less-than flag of its
  // lower neighbor, which marks the insert point without a global search.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                left_lt;
    logic [KEY_BITS-1:0] left_key;
    logic [KEY_BITS-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = entry[i];
    end else begin : g_inner
      assign left_lt  = lt[i-1];
      assign left_key = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = entry[i];
    end else begin : g_body
      assign right_key = entry[i+1];
    end

    skset_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .cmp_key   (cmp_key),
      .position  (req.position),
      .count     (count),
      .ins_key   (key),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .lt        (lt[i]),
      .eq        (eq[i]),
      .sel       (sel[i]),
      .entry     (entry[i]),
      .rd_word   (rd_word[i])
    );
  end

  // At most one cell matches the key and at most one matches the read
  // position, so plain OR reductions gather the answers.
  always_comb begin
    hit      = 1'b0;
    any_sel  = 1'b0;
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit      = hit | eq[i];
      any_sel  = any_sel | sel[i];
      rd_value = rd_value | rd_word[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Operation decode and the response word.
  // ---------------------------------------------------------------------------
  always_comb begin
    ctl.capture   = req_valid && req_ready;
    ctl.do_insert = 1'b0;
    ctl.do_remove = 1'b0;
    count_next    = count;
    rsp_next      = '0;

    case (op)
      skset_pkg::OP_ADD: begin
        rsp_next.was_present = hit;
        if (!hit) begin
          if (full) begin
            rsp_next.full_error = 1'b1;
          end else begin
            rsp_next.changed = 1'b1;
            ctl.do_insert    = commit;
            count_next       = count + CNT_W'(1);
          end
        end
      end
      skset_pkg::OP_REMOVE: begin
        rsp_next.was_present = hit;
        if (hit) begin
          rsp_next.changed = 1'b1;
          ctl.do_remove    = commit;
          count_next       = count - CNT_W'(1);
        end
      end
      skset_pkg::OP_CONTAINS: begin
        rsp_next.was_present = hit;
      end
      skset_pkg::OP_READ: begin
        // A cell flags the read only when the position lies below the count.
        rsp_next.index_error = !any_sel;
        rsp_next.entry_value = skset_pkg::KEY_W'(rd_value);
      end
      default: begin
        rsp_next.was_present = 1'b0;
      end
    endcase

    rsp_next.entry_count = skset_pkg::COUNT_W'(count_next);
  end

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (req_valid) begin
          st_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (commit) begin
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op  <= req.operation;
      key <= cmp_key;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

[tb/sorted_key_set_tb.sv]
// ----------------------------------------------------------------------------
// Sorted key set testbench
// Drives add, remove, contains and read request words into the sorted key
// set. A scoreboard keeps its own ordered copy of the set, predicts each
// response word, and compares every returned word with its prediction field
// by field. Idling and stalls are applied on both sides.
// ----------------------------------------------------------------------------

// Holds a mirror of the key set and the response words still owed by the DUT.
class set_tracker;
  logic [skset_pkg::KEY_W-1:0] keys [skset_pkg::CAPACITY_DEF];
  int unsigned                 held;
  skset_pkg::rsp_t             awaited [$];
  int                          errors;

  function new();
    held   = 0;
    errors = 0;
  endfunction

  // Applies an accepted request word to the mirror and queues its response.
  function void note_request(skset_pkg::req_t r);
    skset_pkg::rsp_t e;
    int unsigned     slot;
    bit              hit;
    e    = '0;
    slot = 0;
    while (slot < held && keys[slot] < r.key) slot++;
    hit = (slot < held) && (keys[slot] == r.key);
    case (r.operation)
      skset_pkg::OP_ADD: begin
        e.was_present = hit;
        if (!hit) begin
          if (held >= skset_pkg::CAPACITY_DEF) begin
            e.full_error = 1'b1;
          end else begin
            for (int i = held; i > slot; i--) keys[i] = keys[i-1];
            keys[slot] = r.key;
            held++;
            e.changed = 1'b1;
          end
        end
      end
      skset_pkg::OP_REMOVE: begin
        e.was_present = hit;
        if (hit) begin
          for (int i = slot; i + 1 < held; i++) keys[i] = keys[i+1];
          held--;
          e.changed = 1'b1;
        end
      end
      skset_pkg::OP_CONTAINS: begin
        e.was_present = hit;
      end
      default: begin
        if (r.position < held) e.entry_value = keys[r.position];
        else e.index_error = 1'b1;
      end
    endcase
    e.entry_count = skset_pkg::COUNT_W'(held);
    awaited.push_back(e);
  endfunction

  function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Checks a returned response word against the oldest prediction.
  function void check_response(skset_pkg::rsp_t got);
    skset_pkg::rsp_t e;
    if (awaited.size() == 0) begin
      $display("%0t: response word with none expected, expected nothing, got %h",
               $time, got);
      errors++;
      return;
    end
    e = awaited.pop_front();
    compare_field("was_present", e.was_present, got.was_present);
    compare_field("changed", e.changed, got.changed);
    compare_field("full_error", e.full_error, got.full_error);
    compare_field("index_error", e.index_error, got.index_error);
    compare_field("entry_value", e.entry_value, got.entry_value);
    compare_field("entry_count", e.entry_count, got.entry_count);
  endfunction
endclass

module sorted_key_set_tb;
  import skset_pkg::*;

  localparam int KEY_POOL   = 96;     // more keys than slots, so the set can fill
  localparam int PHASE_ITEMS = 130;
  localparam int DRAIN_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  set_tracker tracker;

  // Idling knobs, changed only by the main process between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Receiver bookkeeping: responses seen, and the one long hold-off.
  int responses_seen = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  logic [KEY_W-1:0] key_pool [KEY_POOL];

  int send_idle_tab  [4] = '{0, 75, 0, 11};
  int recv_stall_tab [4] = '{0, 0, 75, 11};
  // The add share per phase: fill, drain, fill hard to hit the full case, mix.
  int add_pct_tab    [4] = '{65, 20, 80, 35};

  sorted_key_set dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The run must never take this long, even with every stall at its worst.
  initial begin
    #(12 * 300000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver side. Ready changes on the falling edge. Once sixty responses
  // have been taken, the receiver holds off for a long stretch while the
  // sender keeps offering words, so the output register fills and the DUT
  // has to stall its request side.
  always @(negedge clk) begin
    if (!hold_done && responses_seen >= 60) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Response monitor: sample on the rising edge, where the handshake counts.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      responses_seen++;
      tracker.check_response(rsp);
    end
  end

  function automatic req_t pack_req(op_t op, logic [KEY_W-1:0] k, logic [POS_W-1:0] p);
    req_t r;
    r.operation = op;
    r.key       = k;
    r.position  = p;
    return r;
  endfunction

  // Builds a random request word. Keys come mostly from a fixed pool or from
  // keys already held, so removes and membership tests often hit, with some
  // neighbors of held keys to probe the ordering and some fully random keys.
  function automatic req_t make_request(int add_pct);
    req_t        r;
    int          pick;
    int unsigned n;
    n          = tracker.held;
    r.position = POS_W'($urandom_range(63));
    pick       = $urandom_range(99);
    if (pick < add_pct) r.operation = OP_ADD;
    else if (pick < add_pct + (100 - add_pct) / 3) r.operation = OP_REMOVE;
    else if (pick < add_pct + 2 * (100 - add_pct) / 3) r.operation = OP_CONTAINS;
    else r.operation = OP_READ;
    pick = $urandom_range(99);
    if (pick < 15) begin
      r.key = $urandom;
    end else if (pick < 25 && n > 0) begin
      if ($urandom_range(1) == 1) r.key = tracker.keys[$urandom_range(n - 1)] + 32'd1;
      else r.key = tracker.keys[$urandom_range(n - 1)] - 32'd1;
    end else if (pick < 45 && n > 0) begin
      r.key = tracker.keys[$urandom_range(n - 1)];
    end else begin
      r.key = key_pool[$urandom_range(KEY_POOL - 1)];
    end
    // Most reads land on a held entry; the rest may run past the count.
    if (r.operation == OP_READ && n > 0 && $urandom_range(3) != 0)
      r.position = POS_W'($urandom_range(n - 1));
    return r;
  endfunction

  // Offers one request word, starting and ending on a falling edge. Valid is
  // only lowered during a sender gap, never between two back-to-back words.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    tracker.note_request(r);
    @(negedge clk);
  endtask

  // Sender pause: waits until every predicted response word has come back or
  // the guard limit runs out. It always waits for a falling edge, so valid
  // is never lowered and raised in the same step.
  task automatic wait_drained();
    int guard;
    guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while (tracker.awaited.size() != 0 && guard < DRAIN_LIMIT);
  endtask

  initial begin
    tracker = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with no idling: reads and lookups on the empty set,
    // the extreme keys, a duplicate add, reads at and past the count
    // including the top position, and removal of present and absent keys
    // until the set is empty again.
    send_request(pack_req(OP_READ, '0, '0));
    send_request(pack_req(OP_CONTAINS, '0, '1));
    send_request(pack_req(OP_REMOVE, 32'd5, '0));
    send_request(pack_req(OP_ADD, '0, '1));
    send_request(pack_req(OP_ADD, '1, '0));
    send_request(pack_req(OP_ADD, '0, '0));
    send_request(pack_req(OP_ADD, 32'h8000_0000, '0));
    send_request(pack_req(OP_ADD, 32'd1, '0));
    send_request(pack_req(OP_CONTAINS, '1, '0));
    send_request(pack_req(OP_CONTAINS, 32'd2, '0));
    send_request(pack_req(OP_READ, '1, 6'd0));
    send_request(pack_req(OP_READ, '0, 6'd3));
    send_request(pack_req(OP_READ, '0, 6'd4));
    send_request(pack_req(OP_READ, '0, 6'd63));
    send_request(pack_req(OP_REMOVE, 32'h8000_0000, '0));
    send_request(pack_req(OP_REMOVE, 32'h8000_0000, '1));
    send_request(pack_req(OP_READ, '0, 6'd2));
    send_request(pack_req(OP_REMOVE, '0, '0));
    send_request(pack_req(OP_REMOVE, 32'd1, '0));
    send_request(pack_req(OP_REMOVE, '1, '0));
    send_request(pack_req(OP_READ, '0, 6'd0));
    req_valid <= 1'b0;
    wait_drained();

    // Random phases, each with its own idling pattern and operation mix.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_idle_tab[phase];
      recv_stall_pct = recv_stall_tab[phase];
      repeat (PHASE_ITEMS) send_request(make_request(add_pct_tab[phase]));
      req_valid <= 1'b0;
      wait_drained();
    end

    // Let the clock run on to catch any stray response word.
    repeat (8) @(negedge clk);
    if (tracker.awaited.size() != 0) begin
      $display("%0t: response words missing, expected %0d more, got none",
               $time, tracker.awaited.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/skset_pkg.sv
rtl/skset_cell.sv
rtl/sorted_key_set.sv
tb/sorted_key_set_tb.sv
